// File: src/germ_pkg.sv
package germ_pkg;

	localparam logic [15:0] REPEAT_MASK = 16'h1F7F;
	localparam logic [15:0] DPAD_LEFT   = 16'h0001;
	localparam logic [15:0] DPAD_RIGHT  = 16'h0002;
	localparam logic [15:0] DPAD_DOWN   = 16'h0004;
	localparam logic [15:0] DPAD_UP     = 16'h0008;

	localparam logic [1:0] STAT_NONE     = 2'd0;
	localparam logic [1:0] STAT_TRANSFER = 2'd1;
	localparam logic [1:0] STAT_NOCTRL   = 2'd2;
	localparam logic [1:0] STAT_NOTREADY = 2'd3;

	localparam logic REG_DELAY  = 1'b0;
	localparam logic REG_PERIOD = 1'b1;

	localparam logic [7:0] DELAY_RESET  = 8'd30;
	localparam logic [7:0] PERIOD_RESET = 8'd6;

	typedef struct packed {
		logic              frame_first;
		logic [1:0]        pad_index;
		logic [1:0]        error_code;
		logic [15:0]       buttons;
		logic signed [7:0] stick_x;
		logic signed [7:0] stick_y;
		logic signed [7:0] substick_x;
		logic signed [7:0] substick_y;
		logic [7:0]        trigger_left;
		logic [7:0]        trigger_right;
	} germ_item_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [7:0]  divisor;
	} germ_rem_req_t;

	typedef struct packed {
		logic done;
		logic zero;
	} germ_rem_rsp_t;

	typedef struct packed {
		logic              commit;
		logic              clear;
		logic              pad_ok;
		logic [1:0]        err;
		logic [15:0]       cur;
		logic [15:0]       pressed;
		logic [15:0]       released;
		logic [15:0]       rep;
		logic signed [7:0] stick_x;
		logic signed [7:0] stick_y;
		logic signed [7:0] substick_x;
		logic signed [7:0] substick_y;
		logic [7:0]        trigger_left;
		logic [7:0]        trigger_right;
	} germ_upd_t;

	typedef struct packed {
		logic [15:0]       buttons;
		logic [15:0]       pressed;
		logic [15:0]       released;
		logic [15:0]       rep;
		logic signed [7:0] stick_x;
		logic signed [7:0] stick_y;
		logic signed [7:0] substick_x;
		logic signed [7:0] substick_y;
		logic [7:0]        trigger_left;
		logic [7:0]        trigger_right;
		logic [1:0]        status;
	} germ_frame_t;

	// magnitude of a signed byte; -128 gives 128
	function automatic logic [7:0] mag8(input logic signed [7:0] v);
		logic [7:0] r;
		r = v[7] ? 8'(-v) : 8'(v);
		return r;
	endfunction

endpackage

// File: src/germ_if.sv
interface germ_in_if;
	logic              valid;
	logic              ready;
	logic              frame_first;
	logic [1:0]        pad_index;
	logic [1:0]        error_code;
	logic [15:0]       buttons_in;
	logic signed [7:0] stick_x_in;
	logic signed [7:0] stick_y_in;
	logic signed [7:0] substick_x_in;
	logic signed [7:0] substick_y_in;
	logic [7:0]        trigger_left_in;
	logic [7:0]        trigger_right_in;

	modport source (
		output valid, frame_first, pad_index, error_code, buttons_in,
		       stick_x_in, stick_y_in, substick_x_in, substick_y_in,
		       trigger_left_in, trigger_right_in,
		input  ready
	);
	modport sink (
		input  valid, frame_first, pad_index, error_code, buttons_in,
		       stick_x_in, stick_y_in, substick_x_in, substick_y_in,
		       trigger_left_in, trigger_right_in,
		output ready
	);
endinterface

interface germ_out_if;
	logic              valid;
	logic              ready;
	logic [15:0]       merged_buttons;
	logic [15:0]       merged_pressed;
	logic [15:0]       merged_released;
	logic [15:0]       merged_repeat;
	logic signed [7:0] merged_stick_x;
	logic signed [7:0] merged_stick_y;
	logic signed [7:0] merged_substick_x;
	logic signed [7:0] merged_substick_y;
	logic [7:0]        merged_trigger_left;
	logic [7:0]        merged_trigger_right;
	logic [1:0]        merged_status;

	modport source (
		output valid, merged_buttons, merged_pressed, merged_released, merged_repeat,
		       merged_stick_x, merged_stick_y, merged_substick_x, merged_substick_y,
		       merged_trigger_left, merged_trigger_right, merged_status,
		input  ready
	);
	modport sink (
		input  valid, merged_buttons, merged_pressed, merged_released, merged_repeat,
		       merged_stick_x, merged_stick_y, merged_substick_x, merged_substick_y,
		       merged_trigger_left, merged_trigger_right, merged_status,
		output ready
	);
endinterface

// File: src/gamepad_edge_repeat_merger.sv
// channel | dir | handshake    | word
// in_ch   | in  | valid/ready  | one controller reading
// out_ch  | out | valid/ready  | running frame merge after that reading
// cfg     | in  | cfg_we       | repeat_delay (index 0), repeat_period (index 1)
//
// A reading goes EVAL, DIV (when auto-repeat may fire), COMMIT: the held-count
// remainder by repeat_period goes through a shared 32-step bit-serial unit.
// One reading at a time; in_ch is ready only while the sequencer is idle.
// The result stays on out_ch until taken; the next reading is accepted meanwhile
// but does not commit until that word has gone.
// arst_n clears pad history, the frame merge and the registers to 30 and 6.
module gamepad_edge_repeat_merger #(
	parameter int NUM_PADS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	germ_in_if.sink     in_ch,
	germ_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata
);
	import germ_pkg::*;

	localparam int PW = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EVAL   = 2'd1;
	localparam logic [1:0] S_DIV    = 2'd2;
	localparam logic [1:0] S_COMMIT = 2'd3;

	logic [1:0]  state_q;
	logic [7:0]  delay_q;
	logic [7:0]  period_q;
	germ_item_t  item_q;
	logic        out_valid_q;

	logic [15:0] last_q [NUM_PADS];
	logic [31:0] held_q [NUM_PADS];

	logic [15:0] cur_q, pressed_q, released_q, rep_raw_q;
	logic        hold_q;
	logic        fire_q;
	logic [31:0] cnt_q;

	logic          pad_ok;
	logic [PW-1:0] idx;
	logic [15:0]   prev, cur, pressed, released, rep_raw;
	logic [31:0]   cnt_inc;
	logic          need_div;
	logic          commit;

	germ_rem_req_t rem_req;
	germ_rem_rsp_t rem_rsp;
	germ_upd_t     upd;
	germ_frame_t   frame;

	assign pad_ok = ({30'd0, item_q.pad_index} < NUM_PADS);
	assign idx    = PW'(item_q.pad_index);
	assign prev   = pad_ok ? last_q[idx] : '0;

	always_comb begin
		cur = item_q.buttons;
		if (item_q.error_code == STAT_NONE) begin
			if (item_q.stick_x < 0)
				cur = cur | DPAD_LEFT;
			else if (item_q.stick_x > 0)
				cur = cur | DPAD_RIGHT;
			if (item_q.stick_y < 0)
				cur = cur | DPAD_DOWN;
			else if (item_q.stick_y > 0)
				cur = cur | DPAD_UP;
		end
	end

	assign pressed  = cur & (prev ^ cur);
	assign released = prev & (prev ^ cur);
	assign rep_raw  = cur & prev & REPEAT_MASK;
	assign cnt_inc  = (pad_ok ? held_q[idx] : 32'd0) + 32'd1;
	assign need_div = pad_ok && (item_q.error_code == STAT_NONE) && (rep_raw != 16'd0)
	                  && (cnt_inc >= {24'd0, delay_q}) && (period_q != 8'd0);

	assign rem_req.start    = (state_q == S_EVAL) && need_div;
	assign rem_req.dividend = cnt_inc;
	assign rem_req.divisor  = period_q;

	germ_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	assign commit = (state_q == S_COMMIT) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			delay_q     <= DELAY_RESET;
			period_q    <= PERIOD_RESET;
			for (int p = 0; p < NUM_PADS; p++) begin
				last_q[p] <= '0;
				held_q[p] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DELAY:  delay_q  <= cfg_wdata;
					REG_PERIOD: period_q <= cfg_wdata;
					default:    ;
				endcase
			end
			if (commit)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid)
						state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= need_div ? S_DIV : S_COMMIT;
				end
				S_DIV: begin
					if (rem_rsp.done)
						state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (commit) begin
						state_q <= S_IDLE;
						if (pad_ok && item_q.error_code != STAT_TRANSFER) begin
							last_q[idx] <= cur_q;
							if (item_q.error_code == STAT_NONE)
								held_q[idx] <= hold_q ? cnt_q : 32'd0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			item_q.frame_first   <= in_ch.frame_first;
			item_q.pad_index     <= in_ch.pad_index;
			item_q.error_code    <= in_ch.error_code;
			item_q.buttons       <= in_ch.buttons_in;
			item_q.stick_x       <= in_ch.stick_x_in;
			item_q.stick_y       <= in_ch.stick_y_in;
			item_q.substick_x    <= in_ch.substick_x_in;
			item_q.substick_y    <= in_ch.substick_y_in;
			item_q.trigger_left  <= in_ch.trigger_left_in;
			item_q.trigger_right <= in_ch.trigger_right_in;
		end
		if (state_q == S_EVAL) begin
			cur_q      <= cur;
			pressed_q  <= pressed;
			released_q <= released;
			rep_raw_q  <= rep_raw;
			hold_q     <= (rep_raw != 16'd0);
			cnt_q      <= cnt_inc;
			fire_q     <= 1'b0;
		end else if (state_q == S_DIV && rem_rsp.done) begin
			fire_q <= rem_rsp.zero;
		end
	end

	assign in_ch.ready = (state_q == S_IDLE);

	always_comb begin
		upd.commit        = commit;
		upd.clear         = item_q.frame_first;
		upd.pad_ok        = pad_ok;
		upd.err           = item_q.error_code;
		upd.cur           = cur_q;
		upd.pressed       = pressed_q;
		upd.released      = released_q;
		upd.rep           = (fire_q ? rep_raw_q : 16'd0) | pressed_q;
		upd.stick_x       = item_q.stick_x;
		upd.stick_y       = item_q.stick_y;
		upd.substick_x    = item_q.substick_x;
		upd.substick_y    = item_q.substick_y;
		upd.trigger_left  = item_q.trigger_left;
		upd.trigger_right = item_q.trigger_right;
	end

	germ_frame_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.frame  (frame)
	);

	assign out_ch.valid                = out_valid_q;
	assign out_ch.merged_buttons       = frame.buttons;
	assign out_ch.merged_pressed       = frame.pressed;
	assign out_ch.merged_released      = frame.released;
	assign out_ch.merged_repeat        = frame.rep;
	assign out_ch.merged_stick_x       = frame.stick_x;
	assign out_ch.merged_stick_y       = frame.stick_y;
	assign out_ch.merged_substick_x    = frame.substick_x;
	assign out_ch.merged_substick_y    = frame.substick_y;
	assign out_ch.merged_trigger_left  = frame.trigger_left;
	assign out_ch.merged_trigger_right = frame.trigger_right;
	assign out_ch.merged_status        = frame.status;

endmodule

// File: src/germ_rem_unit.sv
module germ_rem_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  germ_pkg::germ_rem_req_t req,
	output germ_pkg::germ_rem_rsp_t rsp
);
	import germ_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [31:0] quo_q;
	logic [7:0]  rem_q;
	logic [7:0]  div_q;
	logic [8:0]  trial;
	logic [8:0]  rem_next;

	// restoring remainder, one dividend bit a cycle
	assign trial    = {rem_q, quo_q[31]};
	assign rem_next = (trial >= {1'b0, div_q}) ? (trial - {1'b0, div_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], 1'b0};
			rem_q <= rem_next[7:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.zero = (rem_q == 8'd0);

endmodule

// File: src/germ_frame_merge.sv
module germ_frame_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  germ_pkg::germ_upd_t   upd,
	output germ_pkg::germ_frame_t frame
);
	import germ_pkg::*;

	germ_frame_t frame_q;
	germ_frame_t base;
	germ_frame_t nxt;

	always_comb begin
		base = frame_q;
		if (upd.clear) begin
			base        = '0;
			base.status = STAT_NOCTRL;
		end
		nxt = base;
		if (upd.pad_ok) begin
			if (upd.err == STAT_NONE) begin
				nxt.status = STAT_NONE;
			end else if ((upd.err == STAT_TRANSFER || upd.err == STAT_NOTREADY)
			             && base.status == STAT_NOCTRL) begin
				nxt.status = upd.err;
			end
			if (upd.err == STAT_NONE) begin
				nxt.buttons  = base.buttons | upd.cur;
				nxt.pressed  = base.pressed | upd.pressed;
				nxt.released = base.released | upd.released;
				nxt.rep      = base.rep | upd.rep;
				// ties keep the earlier value
				if (mag8(base.stick_x) < mag8(upd.stick_x))
					nxt.stick_x = upd.stick_x;
				if (mag8(base.stick_y) < mag8(upd.stick_y))
					nxt.stick_y = upd.stick_y;
				if (mag8(base.substick_x) < mag8(upd.substick_x))
					nxt.substick_x = upd.substick_x;
				if (mag8(base.substick_y) < mag8(upd.substick_y))
					nxt.substick_y = upd.substick_y;
				if (base.trigger_left < upd.trigger_left)
					nxt.trigger_left = upd.trigger_left;
				if (base.trigger_right < upd.trigger_right)
					nxt.trigger_right = upd.trigger_right;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q        <= '0;
			frame_q.status <= STAT_NOCTRL;
		end else if (upd.commit) begin
			frame_q <= nxt;
		end
	end

	assign frame = frame_q;

endmodule

// File: tb/tb_gamepad_edge_repeat_merger.sv
`timescale 1ns / 1ps

module tb_gamepad_edge_repeat_merger;
	import germ_pkg::*;

	localparam int PADS = 4;
	localparam int HOLD_CYCLES = 300;

	// running merge of pad readings, one expected word per accepted reading
	class merge_scoreboard;
		logic [7:0]  delay;
		logic [7:0]  period;
		logic [15:0] last_btn [PADS];
		logic [31:0] held [PADS];
		germ_frame_t frame;
		germ_frame_t expected [$];
		int failures;
		int readings;
		int words;

		function new();
			delay = DELAY_RESET;
			period = PERIOD_RESET;
			for (int p = 0; p < PADS; p++) begin
				last_btn[p] = '0;
				held[p] = '0;
			end
			clear_frame();
			failures = 0;
			readings = 0;
			words = 0;
		endfunction

		function void clear_frame();
			frame = '0;
			frame.status = STAT_NOCTRL;
		endfunction

		function int magnitude(logic [7:0] v);
			return v[7] ? 256 - int'(v) : int'(v);
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function void note_reading(germ_item_t it);
			logic [15:0] prev;
			logic [15:0] cur;
			logic [15:0] pr;
			logic [15:0] rl;
			logic [15:0] rp;
			logic [31:0] cnt;
			int p;
			p = int'(it.pad_index);
			if (it.frame_first)
				clear_frame();
			if (p < PADS) begin
				if (it.error_code == STAT_NONE)
					frame.status = STAT_NONE;
				else if ((it.error_code == STAT_TRANSFER || it.error_code == STAT_NOTREADY)
						&& frame.status == STAT_NOCTRL)
					frame.status = it.error_code;
				if (it.error_code != STAT_TRANSFER) begin
					prev = last_btn[p];
					cur = it.buttons;
					if (it.error_code == STAT_NONE) begin
						if (it.stick_x[7])
							cur |= DPAD_LEFT;
						else if (it.stick_x != 0)
							cur |= DPAD_RIGHT;
						if (it.stick_y[7])
							cur |= DPAD_DOWN;
						else if (it.stick_y != 0)
							cur |= DPAD_UP;
						pr = cur & ~prev;
						rl = prev & ~cur;
						rp = cur & prev & REPEAT_MASK;
						if (rp != 0) begin
							cnt = held[p] + 32'd1;
							held[p] = cnt;
							if (cnt < {24'd0, delay} || period == 0
									|| (cnt % {24'd0, period}) != 0)
								rp = '0;
						end else begin
							held[p] = '0;
						end
						rp |= pr;
						frame.buttons |= cur;
						frame.pressed |= pr;
						frame.released |= rl;
						frame.rep |= rp;
						// ties keep the earlier value
						if (magnitude(frame.stick_x) < magnitude(it.stick_x))
							frame.stick_x = it.stick_x;
						if (magnitude(frame.stick_y) < magnitude(it.stick_y))
							frame.stick_y = it.stick_y;
						if (magnitude(frame.substick_x) < magnitude(it.substick_x))
							frame.substick_x = it.substick_x;
						if (magnitude(frame.substick_y) < magnitude(it.substick_y))
							frame.substick_y = it.substick_y;
						if (frame.trigger_left < it.trigger_left)
							frame.trigger_left = it.trigger_left;
						if (frame.trigger_right < it.trigger_right)
							frame.trigger_right = it.trigger_right;
					end
					last_btn[p] = cur;
				end
			end
			expected.push_back(frame);
			readings++;
		endfunction

		function void cmp(string name, logic [15:0] e, logic [15:0] g);
			if (e !== g) begin
				$error("%s: expected %0h, got %0h", name, e, g);
				failures++;
			end
		endfunction

		function void check_word(germ_frame_t got);
			germ_frame_t e;
			words++;
			if (expected.size() == 0) begin
				$error("merged word with nothing outstanding");
				failures++;
				return;
			end
			e = expected.pop_front();
			cmp("merged_buttons", e.buttons, got.buttons);
			cmp("merged_pressed", e.pressed, got.pressed);
			cmp("merged_released", e.released, got.released);
			cmp("merged_repeat", e.rep, got.rep);
			cmp("merged_stick_x", {8'd0, e.stick_x}, {8'd0, got.stick_x});
			cmp("merged_stick_y", {8'd0, e.stick_y}, {8'd0, got.stick_y});
			cmp("merged_substick_x", {8'd0, e.substick_x}, {8'd0, got.substick_x});
			cmp("merged_substick_y", {8'd0, e.substick_y}, {8'd0, got.substick_y});
			cmp("merged_trigger_left", {8'd0, e.trigger_left}, {8'd0, got.trigger_left});
			cmp("merged_trigger_right", {8'd0, e.trigger_right}, {8'd0, got.trigger_right});
			cmp("merged_status", {14'd0, e.status}, {14'd0, got.status});
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_wdata;

	germ_in_if  in_ch ();
	germ_out_if out_ch ();

	gamepad_edge_repeat_merger #(.NUM_PADS(PADS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	merge_scoreboard sb;
	bit idling;
	bit hold_req;
	logic [15:0] pad_btn [PADS];
	logic [7:0]  pad_sx [PADS];
	logic [7:0]  pad_sy [PADS];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("** gamepad_edge_repeat_merger: FAILED **");
		$finish;
	end

	// both handshakes sampled on the edge, before any update lands
	always @(posedge clk) begin : watch
		germ_item_t  it;
		germ_frame_t w;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				it.frame_first   = in_ch.frame_first;
				it.pad_index     = in_ch.pad_index;
				it.error_code    = in_ch.error_code;
				it.buttons       = in_ch.buttons_in;
				it.stick_x       = in_ch.stick_x_in;
				it.stick_y       = in_ch.stick_y_in;
				it.substick_x    = in_ch.substick_x_in;
				it.substick_y    = in_ch.substick_y_in;
				it.trigger_left  = in_ch.trigger_left_in;
				it.trigger_right = in_ch.trigger_right_in;
				sb.note_reading(it);
			end
			if (out_ch.valid && out_ch.ready) begin
				w.buttons       = out_ch.merged_buttons;
				w.pressed       = out_ch.merged_pressed;
				w.released      = out_ch.merged_released;
				w.rep           = out_ch.merged_repeat;
				w.stick_x       = out_ch.merged_stick_x;
				w.stick_y       = out_ch.merged_stick_y;
				w.substick_x    = out_ch.merged_substick_x;
				w.substick_y    = out_ch.merged_substick_y;
				w.trigger_left  = out_ch.merged_trigger_left;
				w.trigger_right = out_ch.merged_trigger_right;
				w.status        = out_ch.merged_status;
				sb.check_word(w);
			end
		end
	end

	// result side: random stall bursts, plus one long hold on request
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_ch.ready <= 1'b1;
			end else if (idling && $urandom_range(0, 9) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_reading(germ_item_t it);
		if (idling && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_ch.valid            <= 1'b1;
		in_ch.frame_first      <= it.frame_first;
		in_ch.pad_index        <= it.pad_index;
		in_ch.error_code       <= it.error_code;
		in_ch.buttons_in       <= it.buttons;
		in_ch.stick_x_in       <= it.stick_x;
		in_ch.stick_y_in       <= it.stick_y;
		in_ch.substick_x_in    <= it.substick_x;
		in_ch.substick_y_in    <= it.substick_y;
		in_ch.trigger_left_in  <= it.trigger_left;
		in_ch.trigger_right_in <= it.trigger_right;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic send_fields(logic first, logic [1:0] pad, logic [1:0] err,
			logic [15:0] btn, logic [7:0] sx, logic [7:0] sy, logic [7:0] ssx,
			logic [7:0] ssy, logic [7:0] tl, logic [7:0] tr);
		germ_item_t it;
		it.frame_first   = first;
		it.pad_index     = pad;
		it.error_code    = err;
		it.buttons       = btn;
		it.stick_x       = sx;
		it.stick_y       = sy;
		it.substick_x    = ssx;
		it.substick_y    = ssy;
		it.trigger_left  = tl;
		it.trigger_right = tr;
		send_reading(it);
	endtask

	// lower valid, then wait for every outstanding word
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic set_repeat(logic [7:0] delay, logic [7:0] period);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DELAY;
		cfg_wdata <= delay;
		@(posedge clk);
		cfg_index <= REG_PERIOD;
		cfg_wdata <= period;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.delay = delay;
		sb.period = period;
	endtask

	function automatic logic [7:0] pick_axis();
		case ($urandom_range(0, 7))
			0: return 8'h80;
			1: return 8'h7f;
			2: return 8'h00;
			3: return 8'hff;
			4: return 8'h01;
			default: return 8'($urandom);
		endcase
	endfunction

	// mostly orderly frames of pads 0..3 with buttons held across frames
	task automatic run_phase(int n, bit with_hold);
		germ_item_t it;
		int sent;
		int npads;
		int p;
		sent = 0;
		while (sent < n) begin
			npads = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : PADS;
			for (int k = 0; k < npads && sent < n; k++) begin
				it.frame_first = (k == 0) ^ ($urandom_range(0, 19) == 0);
				it.pad_index = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : 2'(k);
				p = int'(it.pad_index);
				case ($urandom_range(0, 19))
					0: pad_btn[p] = 16'($urandom);
					1, 2: pad_btn[p] ^= 16'(1 << $urandom_range(0, 15));
					default: ;
				endcase
				if ($urandom_range(0, 9) == 0)
					pad_sx[p] = pick_axis();
				if ($urandom_range(0, 9) == 0)
					pad_sy[p] = pick_axis();
				it.error_code = ($urandom_range(0, 9) < 8) ? STAT_NONE
					: 2'($urandom_range(1, 3));
				it.buttons = pad_btn[p];
				it.stick_x = pad_sx[p];
				it.stick_y = pad_sy[p];
				it.substick_x = pick_axis();
				it.substick_y = pick_axis();
				it.trigger_left = ($urandom_range(0, 7) == 0) ? 8'hff : 8'($urandom);
				it.trigger_right = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
				if (with_hold && sent == n / 2)
					hold_req = 1'b1;
				send_reading(it);
				sent++;
			end
		end
	endtask

	initial begin
		sb = new();
		idling = 1'b1;
		hold_req = 1'b0;
		for (int p = 0; p < PADS; p++) begin
			pad_btn[p] = 16'($urandom);
			pad_sx[p] = pick_axis();
			pad_sy[p] = pick_axis();
		end
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_index              <= REG_DELAY;
		cfg_wdata              <= '0;
		in_ch.valid            <= 1'b0;
		in_ch.frame_first      <= 1'b0;
		in_ch.pad_index        <= '0;
		in_ch.error_code       <= '0;
		in_ch.buttons_in       <= '0;
		in_ch.stick_x_in       <= '0;
		in_ch.stick_y_in       <= '0;
		in_ch.substick_x_in    <= '0;
		in_ch.substick_y_in    <= '0;
		in_ch.trigger_left_in  <= '0;
		in_ch.trigger_right_in <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, at reset register values
		send_fields(1, 0, STAT_NONE, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_fields(0, 1, STAT_NONE, 16'hffff, 8'h80, 8'h7f, 8'h80, 8'h7f, 8'hff, 8'hff);
		send_fields(0, 2, STAT_NONE, 16'h0000, 8'h7f, 8'h80, 8'h7f, 8'h81, 8'h00, 8'h00);
		send_fields(0, 3, STAT_TRANSFER, 16'h5555, 8'h80, 8'h80, 8'h80, 8'h80, 8'hff, 8'hff);
		send_fields(1, 0, STAT_NOCTRL, 16'haaaa, 8'h01, 8'h01, 8'h05, 8'h05, 8'h10, 8'h10);
		send_fields(0, 1, STAT_NOTREADY, 16'h0f0f, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00);
		send_fields(0, 2, STAT_TRANSFER, 16'h1234, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_fields(0, 3, STAT_NONE, 16'h8000, 8'h05, 8'hfb, 8'h05, 8'hfb, 8'h01, 8'h02);
		send_fields(0, 0, STAT_NONE, 16'h0001, 8'hfb, 8'h05, 8'hfb, 8'h05, 8'h01, 8'h02);
		send_fields(1, 0, STAT_TRANSFER, 16'hffff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_fields(0, 1, STAT_NOTREADY, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_fields(0, 2, STAT_NOCTRL, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_fields(1, 0, STAT_NONE, 16'h1f7f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_fields(0, 1, STAT_NONE, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_fields(0, 3, STAT_NONE, 16'h8000, 8'h05, 8'hfb, 8'h00, 8'h00, 8'h00, 8'h00);
		send_fields(1, 0, STAT_NONE, 16'h1f7f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_fields(0, 2, STAT_NONE, 16'hffff, 8'h80, 8'h80, 8'h80, 8'h80, 8'hff, 8'hff);
		send_fields(1, 2, STAT_NONE, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		drain();

		// immediate repeat, with the long output hold mid-phase
		set_repeat(8'd0, 8'd1);
		run_phase(120, 1);
		drain();
		set_repeat(8'd3, 8'd2);
		run_phase(100, 0);
		drain();
		set_repeat(8'd255, 8'd255);
		run_phase(80, 0);
		drain();
		// zero period: repeat carries pressed bits only
		set_repeat(8'd5, 8'd0);
		run_phase(100, 0);
		drain();
		set_repeat(8'd1, 8'd7);
		run_phase(100, 0);
		drain();
		idling = 1'b0;
		set_repeat(DELAY_RESET, PERIOD_RESET);
		run_phase(160, 0);
		drain();
		repeat (50) @(posedge clk);

		$display("covered %0d readings and %0d merged words over six repeat settings,",
			sb.readings, sb.words);
		$display("including zero period, delay extremes and a long output hold");
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("** gamepad_edge_repeat_merger: PASSED **");
		end else begin
			$display("** gamepad_edge_repeat_merger: FAILED **");
		end
		$finish;
	end

endmodule

// File: gamepad_edge_repeat_merger.f
src/germ_pkg.sv
src/germ_if.sv
src/germ_rem_unit.sv
src/germ_frame_merge.sv
src/gamepad_edge_repeat_merger.sv
tb/tb_gamepad_edge_repeat_merger.sv
